/* hdl/bec_pkg.sv */
// Package for the button event classifier: mode and event codes,
// register indexes, the configuration register set and the result record.
// No dependencies.
package bec_pkg;

  // Width of the configuration index and write data
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 27;

  // Fixed field widths of the configuration registers
  localparam int unsigned DebounceW  = 20;
  localparam int unsigned LongRelW   = 27;
  localparam int unsigned DelayMsW   = 16;
  localparam int unsigned EdgeTimeW  = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDebounceDelay    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLongReleaseDelay = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLongPushDelay    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTimeOutDelay     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegActiveLow        = 3'd4;

  // Register reset values
  localparam logic [DebounceW-1:0] DebounceRst  = 20'd10000;
  localparam logic [LongRelW-1:0]  LongRelRst   = 27'd1000000;
  localparam logic [DelayMsW-1:0]  LongPushRst  = 16'd1000;
  localparam logic [DelayMsW-1:0]  TimeOutRst   = 16'd5000;
  localparam logic                 ActiveLowRst = 1'b1;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeActive  = 2'd1,
    ModeRelPend = 2'd2,
    ModeToPend  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EvPush     = 3'd0,
    EvShortRel = 3'd1,
    EvLongRel  = 3'd2,
    EvLongPush = 3'd3,
    EvTimeOut  = 3'd4
  } event_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_us;
    logic [LongRelW-1:0]  long_rel_us;
    logic [DelayMsW-1:0]  long_push_ms;
    logic [DelayMsW-1:0]  timeout_ms;
    logic                 active_low;
  } cfg_t;

  typedef struct packed {
    event_e ev;
    mode_e  mode;
  } res_t;

endpackage

/* hdl/button_event_classifier.sv */
// Button event classifier top level: configuration registers, classification
// core and a two-entry result register (output register plus skid stage).
// A result is registered in the output register, or in the skid stage while the output waits.
// Throughput: one item per cycle; input stalls only while the skid stage holds a result.
// Reset clears mode, last edge time, wait count and the result stages, and loads
// the register defaults. Depends on bec_pkg and bec_core.
module button_event_classifier #(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bec_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bec_pkg::CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic                            edge_rise_i,
  input  logic                            edge_fall_i,
  input  logic [bec_pkg::EdgeTimeW-1:0]   edge_time_us_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      event_res_o,
  output logic [1:0]                      button_mode_o
);
  import bec_pkg::*;

  cfg_t cfg_q;
  logic in_acc;
  logic core_valid;
  res_t core_res;
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic out_pop;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_us  <= DebounceRst;
      cfg_q.long_rel_us  <= LongRelRst;
      cfg_q.long_push_ms <= LongPushRst;
      cfg_q.timeout_ms   <= TimeOutRst;
      cfg_q.active_low   <= ActiveLowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDebounceDelay:    cfg_q.debounce_us  <= cfg_data_i[DebounceW-1:0];
        RegLongReleaseDelay: cfg_q.long_rel_us  <= cfg_data_i[LongRelW-1:0];
        RegLongPushDelay:    cfg_q.long_push_ms <= cfg_data_i[DelayMsW-1:0];
        RegTimeOutDelay:     cfg_q.timeout_ms   <= cfg_data_i[DelayMsW-1:0];
        RegActiveLow:        cfg_q.active_low   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Accept items while the skid stage is free
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;

  bec_core #(
    .TIME_WIDTH (TIME_WIDTH),
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_acc_i     (in_acc),
    .cmd_i          (cmd_i),
    .edge_rise_i    (edge_rise_i),
    .edge_fall_i    (edge_fall_i),
    .edge_time_us_i (edge_time_us_i),
    .res_valid_o    (core_valid),
    .res_o          (core_res)
  );

  assign out_pop = out_valid_q & ~out_stall_i;

  // Advance results through the output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (core_valid) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (core_valid) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= core_res;
      end else begin
        out_q <= core_res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_q.ev;
  assign button_mode_o = out_q.mode;

  // The skid stage is only filled behind a waiting result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  // A result parked in the skid stage moves up when the output is taken
  a_skid_moves_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_pop) |=> (out_valid_q && !skid_valid_q))
    else $error("skid result lost on output transfer");

  // A push always leaves the block active, a long push leaves it release pending
  a_push_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_valid && (core_res.ev == EvPush)) |-> (core_res.mode == ModeActive))
    else $error("push result without active mode");

  a_long_push_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_valid && (core_res.ev == EvLongPush)) |-> (core_res.mode == ModeRelPend))
    else $error("long push result without release pending mode");

endmodule

/* hdl/bec_core.sv */
// Classification core of the button event classifier: holds mode, last edge
// time and millisecond wait, and decides the result of each accepted item.
// Depends on bec_pkg.
module bec_core #(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bec_pkg::cfg_t                   cfg_i,
  input  logic                            item_acc_i,
  input  logic                            cmd_i,
  input  logic                            edge_rise_i,
  input  logic                            edge_fall_i,
  input  logic [bec_pkg::EdgeTimeW-1:0]   edge_time_us_i,
  output logic                            res_valid_o,
  output bec_pkg::res_t                   res_o
);
  import bec_pkg::*;

  localparam int unsigned CmpW = (TIME_WIDTH > LongRelW) ? TIME_WIDTH : LongRelW;
  localparam int unsigned LimW = (WAIT_WIDTH > DelayMsW) ? WAIT_WIDTH : DelayMsW;

  mode_e                 mode_q, mode_d;
  logic [TIME_WIDTH-1:0] last_time_q, last_time_d;
  logic [WAIT_WIDTH-1:0] wait_q, wait_d;

  logic [TIME_WIDTH+EdgeTimeW-1:0] time_ext;
  logic [TIME_WIDTH-1:0]           t_now;
  logic [TIME_WIDTH-1:0]           dt;
  logic [CmpW-1:0]                 dt_c;
  logic                            is_push;
  logic [WAIT_WIDTH-1:0]           wait_inc;
  logic [DelayMsW-1:0]             limit;

  // Take the timestamp modulo 2^TIME_WIDTH, elapsed time wraps the same way
  assign time_ext = {{TIME_WIDTH{1'b0}}, edge_time_us_i};
  assign t_now    = time_ext[TIME_WIDTH-1:0];
  assign dt       = t_now - last_time_q;
  assign dt_c     = CmpW'(dt);

  // A push is the active edge seen alone
  assign is_push = cfg_i.active_low ? (edge_fall_i & ~edge_rise_i)
                                    : (edge_rise_i & ~edge_fall_i);

  // Saturating tick count
  assign wait_inc = (wait_q == {WAIT_WIDTH{1'b1}}) ? wait_q : wait_q + WAIT_WIDTH'(1);
  assign limit    = (mode_q == ModeActive) ? cfg_i.long_push_ms
                                           : cfg_i.timeout_ms;

  // Decide next state and result
  always_comb begin
    mode_d      = mode_q;
    last_time_d = last_time_q;
    wait_d      = wait_q;
    res_valid_o = 1'b0;
    res_o.ev    = EvPush;
    res_o.mode  = mode_q;
    if (item_acc_i) begin
      if (!cmd_i) begin
        last_time_d = t_now;
        wait_d      = '0;
        if (dt_c > CmpW'(cfg_i.debounce_us)) begin
          res_valid_o = 1'b1;
          if (is_push) begin
            mode_d   = ModeActive;
            res_o.ev = EvPush;
          end else begin
            mode_d   = ModeToPend;
            res_o.ev = (dt_c < CmpW'(cfg_i.long_rel_us)) ? EvShortRel : EvLongRel;
          end
        end
      end else if (mode_q == ModeActive || mode_q == ModeToPend) begin
        wait_d = wait_inc;
        if (LimW'(wait_inc) >= LimW'(limit)) begin
          wait_d      = '0;
          res_valid_o = 1'b1;
          if (mode_q == ModeActive) begin
            mode_d   = ModeRelPend;
            res_o.ev = EvLongPush;
          end else begin
            mode_d   = ModeIdle;
            res_o.ev = EvTimeOut;
          end
        end
      end
    end
    res_o.mode = mode_d;
  end

  // Hold classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      last_time_q <= '0;
      wait_q      <= '0;
    end else begin
      mode_q      <= mode_d;
      last_time_q <= last_time_d;
      wait_q      <= wait_d;
    end
  end

endmodule
